### design/rv32_pkg.sv
// Shared types and constants for the RV32IM execute block.
`default_nettype none
package rv32_pkg;
  localparam int unsigned MemWordsDefault = 4096;
  localparam logic [31:0] BaseReset = 32'h8000_0000;
  localparam logic [31:0] CauseEcall = 32'h0000_000b;
  localparam logic [31:0] HalfSignFill = 32'hffff_0000;
  localparam logic [4:0] ShiftMask = 5'h1f;

  localparam logic [11:0] CsrMstatus = 12'h300;
  localparam logic [11:0] CsrMtvec = 12'h305;
  localparam logic [11:0] CsrMepc = 12'h341;
  localparam logic [11:0] CsrMcause = 12'h342;

  localparam logic [6:0] OpLui = 7'h37;
  localparam logic [6:0] OpAuipc = 7'h17;
  localparam logic [6:0] OpJal = 7'h6f;
  localparam logic [6:0] OpJalr = 7'h67;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpLoad = 7'h03;
  localparam logic [6:0] OpStore = 7'h23;
  localparam logic [6:0] OpImm = 7'h13;
  localparam logic [6:0] OpReg = 7'h33;
  localparam logic [6:0] OpSystem = 7'h73;

  localparam logic [31:0] InsEcall = 32'h0000_0073;
  localparam logic [31:0] InsEbreak = 32'h0010_0073;
  localparam logic [31:0] InsMret = 32'h3020_0073;

  localparam logic [1:0] StatusNormal = 2'd0;
  localparam logic [1:0] StatusHalt = 2'd1;
  localparam logic [1:0] StatusInvalid = 2'd2;
  localparam logic [1:0] StatusPreload = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_EXEC  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic start;
    logic read;
    logic exec;
    logic div_step;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic is_div;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

### design/rv32_ctrl.sv
// Sequencing state machine for the RV32IM execute block.
`default_nettype none
module rv32_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire rv32_pkg::stat_t stat,
  output rv32_pkg::cmd_t cmd
);
  rv32_pkg::state_t state, state_next;
  logic held, held_next;

  assign in_ready = state == rv32_pkg::ST_IDLE;
  assign out_valid = held;

  always_comb begin
    state_next = state;
    held_next = held && !out_ready;
    cmd = '0;
    case (state)
      rv32_pkg::ST_IDLE: if (in_valid) begin
        cmd.start = 1'b1;
        state_next = rv32_pkg::ST_READ;
      end
      rv32_pkg::ST_READ: begin
        cmd.read = 1'b1;
        state_next = rv32_pkg::ST_EXEC;
      end
      rv32_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        state_next = stat.is_div ? rv32_pkg::ST_DIV : rv32_pkg::ST_WRITE;
      end
      rv32_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = rv32_pkg::ST_WRITE;
      end
      rv32_pkg::ST_WRITE: if (!held || out_ready) begin
        cmd.write = 1'b1;
        held_next = 1'b1;
        state_next = rv32_pkg::ST_IDLE;
      end
      default: state_next = rv32_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rv32_pkg::ST_IDLE;
      held <= 1'b0;
    end else begin
      state <= state_next;
      held <= held_next;
    end
  end
endmodule
`default_nettype wire

### design/rv32_dp.sv
// Datapath: registers, CSRs, data memory, ALU, multiplier and serial divider.
`default_nettype none
module rv32_dp #(
  parameter int unsigned MEMORY_WORDS = rv32_pkg::MemWordsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire rv32_pkg::cmd_t cmd,
  output rv32_pkg::stat_t stat,
  input  wire logic mode,
  input  wire logic [31:0] instruction,
  input  wire logic [11:0] preload_index,
  input  wire logic [31:0] preload_word,
  output logic [31:0] next_pc,
  output logic [4:0] rd_index,
  output logic [31:0] rd_value,
  output logic rd_written,
  output logic [1:0] status,
  output logic [31:0] halt_code
);
  localparam int unsigned AW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;

  logic [31:0] base, pc;
  logic [31:0] regs [32];
  logic [31:0] mem [MEMORY_WORDS];
  logic [31:0] mstatus, mtvec, mepc, mcause;

  logic        mode_q;
  logic [31:0] ins;
  logic [11:0] pidx;
  logic [31:0] pword;
  logic [31:0] a, b, x10, mword, res, npc, mul_hi, mul_lo;
  logic [1:0]  st;
  logic        wr;

  logic [6:0] op, f7;
  logic [4:0] rd, rs1, rs2;
  logic [2:0] f3;
  logic [31:0] immi, imms, immb, immj, eaddr, woff;
  logic        in_range;

  assign op = ins[6:0];
  assign rd = ins[11:7];
  assign f3 = ins[14:12];
  assign rs1 = ins[19:15];
  assign rs2 = ins[24:20];
  assign f7 = ins[31:25];
  assign immi = {{20{ins[31]}}, ins[31:20]};
  assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign immb = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
  assign immj = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
  assign eaddr = a + ((op == rv32_pkg::OpStore) ? imms : immi);
  assign woff = (eaddr - base) >> 2;
  assign in_range = woff < 32'(MEMORY_WORDS);

  // Divider: restoring, one quotient bit a cycle on magnitudes.
  logic [31:0] dq, dr, dd, dv;
  logic [5:0]  dcnt;
  logic        dneg_q, dneg_r, drem;
  logic [32:0] dtrial;
  logic        is_div;

  assign is_div = op == rv32_pkg::OpReg && f7 == 7'h01 && f3[2];
  assign stat.is_div = is_div && b != 32'd0 &&
                       !(!f3[0] && a == 32'h8000_0000 && b == 32'hffff_ffff);
  assign stat.div_done = dcnt == 6'd32;
  assign dtrial = {dr[31:0], dd[31]} - {1'b0, dv};

  // Memory: read registered in the execute step, written in the write step.
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0] mem_wd;

  always_ff @(posedge clk) begin
    if (cmd.exec) mword <= mem[woff[AW-1:0]];
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  // Load alignment and store merge.
  logic [31:0] ld, st_word, smask;
  logic [7:0]  lb;
  logic [15:0] lh;
  always_comb begin
    lb = mword[8*eaddr[1:0] +: 8];
    lh = eaddr[1] ? mword[31:16] : mword[15:0];
    case (f3)
      3'd0: ld = {{24{lb[7]}}, lb};
      3'd1: ld = lh[15] ? (rv32_pkg::HalfSignFill | {16'd0, lh}) : {16'd0, lh};
      3'd4: ld = {24'd0, lb};
      3'd5: ld = {16'd0, lh};
      default: ld = mword;
    endcase
    if (!in_range) ld = (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd4 || f3 == 3'd5 ||
                         f3 == 3'd2) ? 32'd0 : ld;
    case (f3)
      3'd0: smask = 32'hff << (8 * eaddr[1:0]);
      3'd1: smask = eaddr[1] ? 32'hffff_0000 : 32'h0000_ffff;
      default: smask = 32'hffff_ffff;
    endcase
    st_word = (mword & ~smask) | ((b << (8 * ((f3 == 3'd2) ? 2'd0 :
              (f3 == 3'd1 ? {eaddr[1], 1'b0} : eaddr[1:0])))) & smask);
  end

  logic [31:0] csr_old;
  logic        csr_ok;
  always_comb begin
    csr_ok = 1'b1;
    case (ins[31:20])
      rv32_pkg::CsrMstatus: csr_old = mstatus;
      rv32_pkg::CsrMtvec:   csr_old = mtvec;
      rv32_pkg::CsrMepc:    csr_old = mepc;
      rv32_pkg::CsrMcause:  csr_old = mcause;
      default: begin
        csr_old = 32'd0;
        csr_ok = 1'b0;
      end
    endcase
  end

  // Execute step: compute result, status and next pc.
  logic [31:0] x_res, x_npc;
  logic [1:0]  x_st;
  logic        x_wr, taken;
  logic [4:0]  sh;
  always_comb begin
    x_res = 32'd0;
    x_npc = pc + 32'd4;
    x_st = rv32_pkg::StatusNormal;
    x_wr = 1'b0;
    taken = 1'b0;
    sh = (op == rv32_pkg::OpImm) ? rs2 : (b[4:0] & rv32_pkg::ShiftMask);
    case (op)
      rv32_pkg::OpLui: begin x_res = {ins[31:12], 12'd0}; x_wr = 1'b1; end
      rv32_pkg::OpAuipc: begin x_res = pc + {ins[31:12], 12'd0}; x_wr = 1'b1; end
      rv32_pkg::OpJal: begin x_res = pc + 32'd4; x_npc = pc + immj; x_wr = 1'b1; end
      rv32_pkg::OpJalr: begin
        if (f3 != 3'd0) x_st = rv32_pkg::StatusInvalid;
        else begin
          x_res = pc + 32'd4;
          x_npc = (a + immi) & ~32'd1;
          x_wr = 1'b1;
        end
      end
      rv32_pkg::OpBranch: begin
        case (f3)
          3'd0: taken = a == b;
          3'd1: taken = a != b;
          3'd4: taken = $signed(a) < $signed(b);
          3'd5: taken = $signed(a) >= $signed(b);
          3'd6: taken = a < b;
          3'd7: taken = a >= b;
          default: x_st = rv32_pkg::StatusInvalid;
        endcase
        if (taken) x_npc = pc + immb;
      end
      rv32_pkg::OpLoad: begin
        if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) x_st = rv32_pkg::StatusInvalid;
        else x_wr = 1'b1;
      end
      rv32_pkg::OpStore: if (f3 > 3'd2) x_st = rv32_pkg::StatusInvalid;
      rv32_pkg::OpImm: begin
        x_wr = 1'b1;
        case (f3)
          3'd0: x_res = a + immi;
          3'd3: x_res = {31'd0, a < immi};
          3'd4: x_res = a ^ immi;
          3'd6: x_res = a | immi;
          3'd7: x_res = a & immi;
          3'd1: if (f7 == 7'h00) x_res = a << sh; else x_st = rv32_pkg::StatusInvalid;
          3'd5: if (f7 == 7'h00) x_res = a >> sh;
                else if (f7 == 7'h20) x_res = 32'($signed(a) >>> sh);
                else x_st = rv32_pkg::StatusInvalid;
          default: x_st = rv32_pkg::StatusInvalid;
        endcase
      end
      rv32_pkg::OpReg: begin
        x_wr = 1'b1;
        if (f7 == 7'h00) begin
          case (f3)
            3'd0: x_res = a + b;
            3'd1: x_res = a << sh;
            3'd2: x_res = {31'd0, $signed(a) < $signed(b)};
            3'd3: x_res = {31'd0, a < b};
            3'd4: x_res = a ^ b;
            3'd5: x_res = a >> sh;
            3'd6: x_res = a | b;
            default: x_res = a & b;
          endcase
        end else if (f7 == 7'h20 && f3 == 3'd0) x_res = a - b;
        else if (f7 == 7'h20 && f3 == 3'd5) x_res = 32'($signed(a) >>> sh);
        else if (f7 == 7'h01) begin
          case (f3)
            3'd0: x_res = 32'd0;
            3'd1: x_res = 32'd0;
            3'd4: x_res = (b == 32'd0) ? 32'hffff_ffff : 32'h8000_0000;
            3'd5: x_res = 32'hffff_ffff;
            3'd6: x_res = (b == 32'd0) ? a : 32'd0;
            3'd7: x_res = a;
            default: x_st = rv32_pkg::StatusInvalid;
          endcase
        end else x_st = rv32_pkg::StatusInvalid;
      end
      rv32_pkg::OpSystem: begin
        if (ins == rv32_pkg::InsEcall) x_npc = mtvec;
        else if (ins == rv32_pkg::InsEbreak) begin
          x_st = rv32_pkg::StatusHalt;
          x_npc = pc;
        end else if (ins == rv32_pkg::InsMret) x_npc = mepc;
        else if ((f3 == 3'd1 || f3 == 3'd2) && csr_ok) begin
          x_res = csr_old;
          x_wr = 1'b1;
        end else x_st = rv32_pkg::StatusInvalid;
      end
      default: x_st = rv32_pkg::StatusInvalid;
    endcase
    if (x_st == rv32_pkg::StatusInvalid) begin
      x_npc = pc;
      x_wr = 1'b0;
    end
  end

  logic signed [63:0] prod;
  assign prod = $signed(a) * $signed(b);

  logic [31:0] dq_fin, dr_fin;
  assign dq_fin = dneg_q ? (32'd0 - dq) : dq;
  assign dr_fin = dneg_r ? (32'd0 - dr) : dr;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_q <= mode;
      ins <= instruction;
      pidx <= preload_index;
      pword <= preload_word;
    end
    if (cmd.read && !mode_q) begin
      a <= regs[rs1];
      b <= regs[rs2];
      x10 <= regs[10];
    end
    if (cmd.exec) begin
      mul_lo <= prod[31:0];
      mul_hi <= prod[63:32];
      res <= x_res;
      npc <= x_npc;
      st <= x_st;
      wr <= x_wr;
      drem <= f3[1];
      dneg_q <= !f3[0] && (a[31] ^ b[31]);
      dneg_r <= !f3[0] && a[31];
      dd <= (!f3[0] && a[31]) ? 32'd0 - a : a;
      dv <= (!f3[0] && b[31]) ? 32'd0 - b : b;
      dq <= 32'd0;
      dr <= 32'd0;
      dcnt <= 6'd0;
    end
    if (cmd.div_step && !stat.div_done) begin
      dd <= {dd[30:0], 1'b0};
      dcnt <= dcnt + 6'd1;
      if (!dtrial[32]) begin
        dr <= dtrial[31:0];
        dq <= {dq[30:0], 1'b1};
      end else begin
        dr <= {dr[30:0], dd[31]};
        dq <= {dq[30:0], 1'b0};
      end
    end
    if (cmd.div_step && stat.div_done) res <= drem ? dr_fin : dq_fin;
  end

  // The product is latched in the execute step; loads align the word read then.
  logic is_mul;
  assign is_mul = op == rv32_pkg::OpReg && f7 == 7'h01 && !f3[2];

  logic [31:0] fin_res;
  assign fin_res = is_mul ? (f3[0] ? mul_hi : mul_lo) :
                   ((op == rv32_pkg::OpLoad) ? ld : res);
  assign mem_we = cmd.write && (mode_q ? ({20'd0, pidx} < 32'(MEMORY_WORDS)) :
                  (op == rv32_pkg::OpStore && st == rv32_pkg::StatusNormal && in_range));
  assign mem_wa = mode_q ? AW'(pidx) : woff[AW-1:0];
  assign mem_wd = mode_q ? pword : st_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= rv32_pkg::BaseReset;
      pc <= rv32_pkg::BaseReset;
      mstatus <= 32'd0;
      mtvec <= 32'd0;
      mepc <= 32'd0;
      mcause <= 32'd0;
      for (int i = 0; i < 32; i++) regs[i] <= 32'd0;
    end else if (cfg_we) begin
      base <= cfg_data;
      pc <= cfg_data;
    end else if (cmd.write) begin
      next_pc <= mode_q ? pc : npc;
      halt_code <= (!mode_q && st == rv32_pkg::StatusHalt) ? x10 : 32'd0;
      status <= mode_q ? rv32_pkg::StatusPreload : st;
      if (!mode_q && wr && rd != 5'd0) begin
        regs[rd] <= fin_res;
        rd_index <= rd;
        rd_value <= fin_res;
        rd_written <= 1'b1;
      end else begin
        rd_index <= 5'd0;
        rd_value <= 32'd0;
        rd_written <= 1'b0;
      end
      if (!mode_q) begin
        pc <= npc;
        if (op == rv32_pkg::OpSystem && st == rv32_pkg::StatusNormal) begin
          if (ins == rv32_pkg::InsEcall) begin
            mepc <= pc;
            mcause <= rv32_pkg::CauseEcall;
          end else if (ins != rv32_pkg::InsEbreak && ins != rv32_pkg::InsMret) begin
            case (ins[31:20])
              rv32_pkg::CsrMstatus: mstatus <= f3 == 3'd1 ? a : (csr_old | a);
              rv32_pkg::CsrMtvec:   mtvec <= f3 == 3'd1 ? a : (csr_old | a);
              rv32_pkg::CsrMepc:    mepc <= f3 == 3'd1 ? a : (csr_old | a);
              rv32_pkg::CsrMcause:  mcause <= f3 == 3'd1 ? a : (csr_old | a);
              default: ;
            endcase
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### design/rv32im_instruction_execute.sv
// Top level of the RV32IM instruction execute block.
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     mode, instruction, preload_index, preload_word
//   out      output     out_valid / out_ready   next_pc, rd_index, rd_value, rd_written, ...
//   cfg      input      cfg_we                  cfg_data (memory_base)
// After acceptance an item passes the read, execute and write steps; div, divu, rem
// and remu also pass the bit-serial divider, bar a zero divisor or signed overflow.
// The result register frees the input side: the next transaction is taken while a
// result waits. A stalled output holds the next item in its write step. Reset is synchronous.
`default_nettype none
module rv32im_instruction_execute #(
  parameter int unsigned MEMORY_WORDS = rv32_pkg::MemWordsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic mode,
  input  wire logic [31:0] instruction,
  input  wire logic [11:0] preload_index,
  input  wire logic [31:0] preload_word,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [31:0] next_pc,
  output logic [4:0] rd_index,
  output logic [31:0] rd_value,
  output logic rd_written,
  output logic [1:0] status,
  output logic [31:0] halt_code
);
  rv32_pkg::cmd_t cmd;
  rv32_pkg::stat_t stat;

  rv32_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  rv32_dp #(.MEMORY_WORDS(MEMORY_WORDS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .cmd, .stat, .mode, .instruction,
    .preload_index, .preload_word, .next_pc, .rd_index, .rd_value,
    .rd_written, .status, .halt_code
  );

  a_written_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && rd_written |-> rd_index != 5'd0)
    else $error("register write reported for x0");
  a_preload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rv32_pkg::StatusPreload |-> !rd_written)
    else $error("preload reported a register write");
  a_halt_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != rv32_pkg::StatusHalt |-> halt_code == 32'd0)
    else $error("halt code outside halt");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.read, cmd.exec, cmd.div_step, cmd.write}))
    else $error("overlapping controller commands");
endmodule
`default_nettype wire
